### design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// pre holds, so post holds in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("%m: implication check failed");
// pre holds, so post holds in the next cycle
`define ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, ck, rs, pre, post)
`define ASSERT_NEXT(lbl, ck, rs, pre, post)
`endif
`endif

### design/tba_pkg.sv
package tba_pkg;

  localparam int DATA_W = 32;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int SETTLE_CYCLES = 2;

  // queue depths
  localparam int FRONT_Q_DEPTH = 4;
  localparam int RESULT_Q_DEPTH = 16;

  typedef enum logic {
    CMD_LOAD_B = 1'b0,
    CMD_ADD_A  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_DIM0_LEN   = 3'd0,
    REG_DIM1_LEN   = 3'd1,
    REG_DIM2_LEN   = 3'd2,
    REG_DIM3_LEN   = 3'd3,
    REG_BCAST_MASK = 3'd4
  } reg_idx_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sum;
    logic                     last;
  } out_word_t;

endpackage

### design/tba_fifo.sv
module tba_fifo #(
  parameter int DEPTH = 4,
  parameter type word_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  word_t wdata,
  input  logic  pop,
  output logic  empty,
  output word_t rdata
);

  localparam int PTR_W = $clog2(DEPTH) + 1;

  word_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[PTR_W-1] != rd_ptr[PTR_W-1]) &&
                 (wr_ptr[PTR_W-2:0] == rd_ptr[PTR_W-2:0]);
  assign rdata = mem[rd_ptr[PTR_W-2:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[PTR_W-2:0]] <= wdata;
    end
  end

endmodule

### design/tba_ram.sv
module tba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/tba_front.sv
module tba_front #(
  parameter int DIM_MAX = 8,
  parameter type work_t = logic,
  localparam int PW  = $clog2(DIM_MAX),
  localparam int LW  = $clog2(DIM_MAX + 1),
  localparam int BIW = $clog2(DIM_MAX ** 4),
  localparam int CW  = $clog2(DIM_MAX ** 4 + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tba_pkg::in_word_t   item,
  input  logic [3:0][LW-1:0]  elen,
  input  logic [3:0]          bmask,
  input  logic [CW-1:0]       count,
  input  logic                busy,
  output logic                q_push,
  input  logic                q_full,
  output work_t               entry
);

  import tba_pkg::*;

  logic [3:0][PW-1:0] pos;
  logic [3:0][PW-1:0] pos_next;
  logic [BIW-1:0]     wptr;
  logic [BIW-1:0]     wptr_next;
  logic [3:0]         at_last;
  logic               carry;

  assign full   = q_full || busy;
  assign q_push = push && !full;

  // a counter at or past its last index counts as being there
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      at_last[d] = (LW'(pos[d]) + LW'(1)) >= elen[d];
    end
  end

  // row-major advance, innermost dimension first
  always_comb begin
    pos_next = pos;
    carry    = 1'b1;
    for (int d = 3; d >= 0; d--) begin
      if (carry) begin
        if (at_last[d]) begin
          pos_next[d] = '0;
        end else begin
          pos_next[d] = pos[d] + PW'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  assign wptr_next = ((CW'(wptr) + CW'(1)) >= count) ? '0 : wptr + BIW'(1);

  always_comb begin
    entry.command = item.command;
    entry.value   = item.value;
    entry.last    = &at_last;
    entry.wptr    = wptr;
    for (int d = 0; d < 4; d++) begin
      entry.pos[d] = bmask[d] ? '0 : pos[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      wptr <= '0;
    end else if (q_push) begin
      if (item.command == CMD_LOAD_B) begin
        wptr <= wptr_next;
      end else begin
        pos <= pos_next;
      end
    end
  end

endmodule

### design/tba_back.sv
`include "assert_macros.svh"

module tba_back #(
  parameter int DIM_MAX = 8,
  parameter int B_DEPTH = 4096,
  parameter type work_t = logic,
  localparam int PW  = $clog2(DIM_MAX),
  localparam int LW  = $clog2(DIM_MAX + 1),
  localparam int BIW = $clog2(DIM_MAX ** 4),
  localparam int AW  = $clog2(B_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0][LW-1:0]   blen,
  input  work_t                head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output tba_pkg::out_word_t   result,
  output logic                 empty,
  input  logic                 pop
);

  import tba_pkg::*;

  localparam int XW    = (BIW > AW) ? BIW : AW;
  localparam int RECIP = (1 << XW) / B_DEPTH;
  localparam int RES_W = $clog2(RESULT_Q_DEPTH + 1);

  typedef struct packed {
    cmd_t              command;
    logic              last;
    logic [DATA_W-1:0] value;
  } tag_t;

  logic             v1, v2, v3, v4, v5, v6;
  tag_t             g1, g2, g3, g4, g5, g6;
  logic [BIW-1:0]   t1, t2;
  logic [PW-1:0]    p2_1, p3_1, p3_2;
  logic [BIW-1:0]   wp1, wp2;
  logic [XW-1:0]    x3, x4, q4, r5;
  logic [2*XW-1:0]  prod;
  logic [2*XW-1:0]  qd;
  logic [XW:0]      r_ext;
  logic [XW:0]      fold;
  logic [AW-1:0]    addr;
  logic [DATA_W-1:0] rdata;
  logic             issue;
  logic             drain;
  logic [RES_W-1:0] reserved;
  logic             out_push;
  logic             out_full;
  out_word_t        out_word;

  // result slots are reserved at issue so the pipeline never stalls
  assign issue = !q_empty &&
                 (head.command == CMD_LOAD_B || reserved < RES_W'(RESULT_Q_DEPTH));
  assign q_pop = issue;
  assign drain = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + RES_W'(issue && head.command == CMD_ADD_A) - RES_W'(drain);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // modulo by the store depth via reciprocal
  assign prod  = (2*XW)'(x3) * (2*XW)'(RECIP);
  assign qd    = (2*XW)'(q4) * (2*XW)'(B_DEPTH);
  assign r_ext = {1'b0, r5};
  assign fold  = (r_ext >= (XW+1)'(B_DEPTH)) ? r_ext - (XW+1)'(B_DEPTH) : r_ext;
  assign addr  = fold[AW-1:0];

  always_ff @(posedge clk) begin
    // flat index of the b element, one multiply per stage
    g1   <= '{command: head.command, last: head.last, value: head.value};
    t1   <= BIW'(head.pos[0]) * BIW'(blen[1]) + BIW'(head.pos[1]);
    p2_1 <= head.pos[2];
    p3_1 <= head.pos[3];
    wp1  <= head.wptr;

    g2   <= g1;
    t2   <= t1 * BIW'(blen[2]) + BIW'(p2_1);
    p3_2 <= p3_1;
    wp2  <= wp1;

    g3   <= g2;
    x3   <= (g2.command == CMD_ADD_A) ? XW'(t2 * BIW'(blen[3]) + BIW'(p3_2)) : XW'(wp2);

    g4   <= g3;
    x4   <= x3;
    q4   <= prod[2*XW-1:XW];

    g5   <= g4;
    r5   <= x4 - qd[XW-1:0];

    g6   <= g5;
  end

  tba_ram #(
    .WIDTH (DATA_W),
    .DEPTH (B_DEPTH)
  ) u_bstore (
    .clk   (clk),
    .we    (v5 && g5.command == CMD_LOAD_B),
    .re    (v5 && g5.command == CMD_ADD_A),
    .addr  (addr),
    .wdata (g5.value),
    .rdata (rdata)
  );

  assign out_push      = v6 && g6.command == CMD_ADD_A;
  assign out_word.sum  = g6.value + rdata;
  assign out_word.last = g6.last;

  tba_fifo #(
    .DEPTH  (RESULT_Q_DEPTH),
    .word_t (out_word_t)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (out_word),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

  `ASSERT_IMPLIES(a_out_room, clk, rst, out_push, !out_full)
  `ASSERT_IMPLIES(a_credit_bound, clk, rst, 1'b1, reserved <= RES_W'(RESULT_Q_DEPTH))
  `ASSERT_IMPLIES(a_drain_credit, clk, rst, drain, reserved != '0)

endmodule

### design/tensor4d_broadcast_add.sv
// an add goes via the work queue, back pipeline and result queue to the result ports
// throughput: one word per cycle for loads and adds, unless settling, with pop high
// the b store is a single-port ram; each word uses it once, in pipeline order
// after a config write the input shows full while the b count settles
// reset (rst, synchronous): lengths 1, mask 0, counters and pointer 0, queues empty
// the b store is not cleared; entries read before being written are undefined
module tensor4d_broadcast_add #(
  parameter int DIM_MAX = 8,
  parameter int B_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // input word queue side
  input  logic                          push,
  output logic                          full,
  input  tba_pkg::in_word_t             item,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output tba_pkg::out_word_t            result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tba_pkg::ADDR_W-1:0]    paddr,
  input  logic [tba_pkg::PDATA_W-1:0]   pwdata,
  output logic [tba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import tba_pkg::*;

  localparam int PW  = $clog2(DIM_MAX);
  localparam int LW  = $clog2(DIM_MAX + 1);
  localparam int BIW = $clog2(DIM_MAX ** 4);
  localparam int CW  = $clog2(DIM_MAX ** 4 + 1);

  // one classified word on its way from front to back
  typedef struct packed {
    cmd_t               command;
    logic               last;
    logic [3:0][PW-1:0] pos;
    logic [BIW-1:0]     wptr;
    logic [DATA_W-1:0]  value;
  } work_t;

  logic [3:0][3:0]    dim_len;
  logic [3:0]         bcast_mask;
  logic [3:0][LW-1:0] elen;
  logic [3:0][LW-1:0] blen;
  logic [2*LW-1:0]    c01;
  logic [2*LW-1:0]    c23;
  logic [CW-1:0]      count;
  logic [1:0]         settle;
  logic               busy;
  logic               cfg_wr;

  work_t              fq_wdata;
  work_t              fq_head;
  logic               fq_push;
  logic               fq_full;
  logic               fq_pop;
  logic               fq_empty;

  // ---------------------------------------------------------------
  // configuration registers, always ready, written in the access phase
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_len    <= {4{4'd1}};
      bcast_mask <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_DIM0_LEN:   dim_len[0] <= pwdata[3:0];
        REG_DIM1_LEN:   dim_len[1] <= pwdata[3:0];
        REG_DIM2_LEN:   dim_len[2] <= pwdata[3:0];
        REG_DIM3_LEN:   dim_len[3] <= pwdata[3:0];
        REG_BCAST_MASK: bcast_mask <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // readback, unmapped addresses read zero
  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[4:2]))
      REG_DIM0_LEN:   prdata = PDATA_W'(dim_len[0]);
      REG_DIM1_LEN:   prdata = PDATA_W'(dim_len[1]);
      REG_DIM2_LEN:   prdata = PDATA_W'(dim_len[2]);
      REG_DIM3_LEN:   prdata = PDATA_W'(dim_len[3]);
      REG_BCAST_MASK: prdata = PDATA_W'(bcast_mask);
      default:        prdata = '0;
    endcase
  end

  // effective lengths: zero acts as one, above the maximum clamps to it
  // b's length is one in every broadcast dimension
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      if (dim_len[d] == 4'd0) begin
        elen[d] = LW'(1);
      end else if (int'(dim_len[d]) > DIM_MAX) begin
        elen[d] = LW'(DIM_MAX);
      end else begin
        elen[d] = LW'(dim_len[d]);
      end
      blen[d] = bcast_mask[d] ? LW'(1) : elen[d];
    end
  end

  // b element count, two multiply stages; loads wait until it has settled
  always_ff @(posedge clk) begin
    if (rst) begin
      c01    <= (2*LW)'(1);
      c23    <= (2*LW)'(1);
      count  <= CW'(1);
      settle <= '0;
    end else begin
      c01   <= (2*LW)'(blen[0]) * (2*LW)'(blen[1]);
      c23   <= (2*LW)'(blen[2]) * (2*LW)'(blen[3]);
      count <= CW'((4*LW)'(c01) * (4*LW)'(c23));
      if (cfg_wr) begin
        settle <= 2'(SETTLE_CYCLES);
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  assign busy = (settle != 2'd0);

  // ---------------------------------------------------------------
  // front: position counters and load pointer, when not full one word per cycle
  // ---------------------------------------------------------------
  tba_front #(
    .DIM_MAX (DIM_MAX),
    .work_t  (work_t)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .elen   (elen),
    .bmask  (bcast_mask),
    .count  (count),
    .busy   (busy),
    .q_push (fq_push),
    .q_full (fq_full),
    .entry  (fq_wdata)
  );

  // short queue lets the front keep accepting while the back catches up
  tba_fifo #(
    .DEPTH  (FRONT_Q_DEPTH),
    .word_t (work_t)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_wdata),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_head)
  );

  // ---------------------------------------------------------------
  // back: index arithmetic, b store access, add, result queue
  // ---------------------------------------------------------------
  tba_back #(
    .DIM_MAX (DIM_MAX),
    .B_DEPTH (B_DEPTH),
    .work_t  (work_t)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .blen    (blen),
    .head    (fq_head),
    .q_empty (fq_empty),
    .q_pop   (fq_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
